// ===== hdl/ihex_pkg.sv =====
package ihex_pkg;

    localparam int ADDR_W       = 3;
    localparam int REG_IDX_W    = 1;
    localparam int POS_W        = 10;
    localparam int WIDX_W       = 7;

    // register index, taken from paddr above the byte-lane bits
    localparam logic [REG_IDX_W-1:0] REG_HIGH_BASE = 1'b0;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;

    // character positions after ':'
    localparam logic [POS_W-1:0] POS_FIRST      = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_LAST = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 10'd6;
    localparam logic [POS_W-1:0] POS_DATA_START = 10'd9;

    // upper-case hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'h00;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            diff = c - CHAR_0;
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            diff = c - CHAR_A + 8'd10;
        end
        return diff[3:0];
    endfunction

endpackage

// ===== hdl/intel_hex_record_word_parser.sv =====
// A word appears on word_value in the cycle after its fourth data digit is taken.
// Throughput: one character per cycle while char_stall is low; one state update plus digit decode per beat.
// The output register parts the sides: char_stall rises only when a word is held
// and word_stall is high.
// Reset (rst_n low, asynchronous): no record active, output empty, high base zero.
module intel_hex_record_word_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ihex_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // character channel
    input  logic                            char_valid,
    output logic                            char_stall,
    input  logic [7:0]                      ascii_char,
    // word channel
    output logic                            word_valid,
    input  logic                            word_stall,
    output logic [31:0]                     record_address,
    output logic [ihex_pkg::WIDX_W-1:0]     word_index,
    output logic [15:0]                     word_value,
    output logic                            last_word
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [31:0] high_base_reg;
    logic        cfg_hit;

    assign pready  = 1'b1;
    // register index sits above the two byte-lane bits
    assign cfg_hit = (paddr[ihex_pkg::ADDR_W-1 -: ihex_pkg::REG_IDX_W]
                      == ihex_pkg::REG_HIGH_BASE);
    assign prdata  = cfg_hit ? high_base_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_base_reg <= 32'h0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            high_base_reg <= pwdata;
        end
    end

    // ---------------------------------------------------------------
    // Record parse state
    // ---------------------------------------------------------------
    logic [ihex_pkg::POS_W-1:0]  pos_reg,    pos_next;
    logic                        active_reg, active_next;
    logic [7:0]                  count_reg,  count_next;
    logic [15:0]                 laddr_reg,  laddr_next;
    logic [11:0]                 acc_reg,    acc_next;
    logic [ihex_pkg::WIDX_W-1:0] nwords_reg, nwords_next;

    // output register
    logic                        ovalid_reg, ovalid_next;
    logic [31:0]                 oaddr_reg;
    logic [ihex_pkg::WIDX_W-1:0] oidx_reg;
    logic [15:0]                 oval_reg;
    logic                        olast_reg;

    logic                        char_fire;
    logic                        is_colon;
    logic [3:0]                  digit;
    logic [ihex_pkg::WIDX_W-1:0] total;     // byte_count / 2
    logic                        emit;      // this beat completes a word
    logic                        emit_last;
    logic [ihex_pkg::WIDX_W:0]   nwords_inc;
    logic [15:0]                 word;

    // output register can take a new word when empty or being drained
    assign char_stall = ovalid_reg && word_stall;
    assign char_fire  = char_valid && !char_stall;

    assign is_colon   = (ascii_char == ihex_pkg::CHAR_COLON);
    assign digit      = ihex_pkg::hex_digit(ascii_char);
    assign total      = count_reg[7:1];
    assign nwords_inc = {1'b0, nwords_reg} + 1'b1;
    assign word       = {acc_reg, digit};
    assign emit_last  = (nwords_inc >= {1'b0, total});
    // data phase: digit four of a word lands where pos is a multiple of 4
    assign emit       = active_reg && !is_colon
                        && (pos_reg >= ihex_pkg::POS_DATA_START)
                        && (pos_reg[1:0] == 2'b00);

    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        count_next  = count_reg;
        laddr_next  = laddr_reg;
        acc_next    = acc_reg;
        nwords_next = nwords_reg;

        if (char_fire)
        begin
            if (is_colon)
            begin
                // ':' restarts, dropping any partial word
                active_next = 1'b1;
                pos_next    = ihex_pkg::POS_FIRST;
                count_next  = 8'h0;
                laddr_next  = 16'h0;
                acc_next    = 12'h0;
                nwords_next = '0;
            end
            else if (active_reg)
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg <= ihex_pkg::POS_COUNT_LAST)
                begin
                    count_next = {count_reg[3:0], digit};
                end
                else if (pos_reg <= ihex_pkg::POS_ADDR_LAST)
                begin
                    laddr_next = {laddr_reg[11:0], digit};
                end

                if (pos_reg < ihex_pkg::POS_DATA_START)
                begin
                    // type digits done with fewer than two data bytes: go idle
                    if ((pos_next == ihex_pkg::POS_DATA_START)
                        && (count_reg[7:1] == '0))
                    begin
                        active_next = 1'b0;
                    end
                end
                else if (emit)
                begin
                    acc_next    = 12'h0;
                    nwords_next = nwords_inc[ihex_pkg::WIDX_W-1:0];
                    if (emit_last)
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    acc_next = {acc_reg[7:0], digit};
                end
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (char_fire)
        begin
            ovalid_next = emit;
        end
        else if (!word_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
            count_reg  <= 8'h0;
            laddr_reg  <= 16'h0;
            acc_reg    <= 12'h0;
            nwords_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            laddr_reg  <= laddr_next;
            acc_reg    <= acc_next;
            nwords_reg <= nwords_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (char_fire && emit)
        begin
            oaddr_reg <= high_base_reg | {16'h0, laddr_reg};
            oidx_reg  <= nwords_reg;
            oval_reg  <= word;
            olast_reg <= emit_last;
        end
    end

    assign word_valid     = ovalid_reg;
    assign record_address = oaddr_reg;
    assign word_index     = oidx_reg;
    assign word_value     = oval_reg;
    assign last_word      = olast_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> word_valid)
        else $error("char_stall high with empty output register");

    a_last_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && emit && emit_last) |=> !active_reg)
        else $error("record still active after last word");

    a_colon_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && is_colon) |=> (active_reg && pos_reg == ihex_pkg::POS_FIRST
                                     && nwords_reg == '0))
        else $error("':' did not restart the record");

    a_emit_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (pos_reg >= ihex_pkg::POS_DATA_START && active_reg))
        else $error("word emitted outside data field");

    a_word_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && emit) |=> (word_valid && word_index == $past(nwords_reg)))
        else $error("emitted word not loaded into output register");

endmodule

// ===== test/ihex_word_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the word beats
// and compares them in order.
module ihex_word_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [ihex_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            char_valid,
    input  logic                            char_stall,
    input  logic [7:0]                      ascii_char,
    input  logic                            word_valid,
    input  logic                            word_stall,
    input  logic [31:0]                     record_address,
    input  logic [ihex_pkg::WIDX_W-1:0]     word_index,
    input  logic [15:0]                     word_value,
    input  logic                            last_word,
    output int                              fail_count,
    output int                              words_outstanding
);

    typedef struct packed
    {
        logic [31:0]                    address;
        logic [ihex_pkg::WIDX_W-1:0]    index;
        logic [15:0]                    value;
        logic                           last;
    } word_beat_t;

    word_beat_t                     expected_words[$];

    // shadow of the parser state
    logic [31:0]                    base_addr;
    logic [ihex_pkg::POS_W-1:0]     char_pos;
    logic                           in_record;
    logic [7:0]                     byte_cnt;
    logic [15:0]                    load_addr;
    logic [11:0]                    partial_word;
    logic [ihex_pkg::WIDX_W-1:0]    words_out;
    int                             mismatches = 0;

    assign fail_count = mismatches;

    // '0'..'9' carry the digit in the low nibble, 'A'..'F' need +9
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= ihex_pkg::CHAR_0 && c <= ihex_pkg::CHAR_9)
            return c[3:0];
        if (c >= ihex_pkg::CHAR_A && c <= ihex_pkg::CHAR_F)
            return c[3:0] + 4'd9;
        return 4'h0;
    endfunction

    task automatic predict_char(input logic [7:0] c);
        logic [3:0]                     d;
        logic [ihex_pkg::POS_W-1:0]     p;
        logic [ihex_pkg::POS_W-1:0]     data_off;
        logic [6:0]                     half;
        word_beat_t                     w;
        d = nibble_of(c);
        p = char_pos;
        half = byte_cnt[7:1];
        data_off = p - ihex_pkg::POS_DATA_START;
        if (c == ihex_pkg::CHAR_COLON)
        begin
            in_record = 1'b1;
            char_pos = ihex_pkg::POS_FIRST;
            byte_cnt = 8'h00;
            load_addr = 16'h0000;
            partial_word = 12'h000;
            words_out = '0;
        end
        else if (in_record)
        begin
            if (p <= ihex_pkg::POS_COUNT_LAST)
                byte_cnt = {byte_cnt[3:0], d};
            else if (p <= ihex_pkg::POS_ADDR_LAST)
                load_addr = {load_addr[11:0], d};
            char_pos = p + 1'b1;
            if (p < ihex_pkg::POS_DATA_START)
            begin
                // header over and less than one word to carry
                if (char_pos == ihex_pkg::POS_DATA_START && byte_cnt[7:1] == 7'd0)
                    in_record = 1'b0;
            end
            else if (data_off[1:0] != 2'd3)
            begin
                partial_word = {partial_word[7:0], d};
            end
            else
            begin
                w.address = base_addr | {16'h0000, load_addr};
                w.index = words_out;
                w.value = {partial_word, d};
                w.last = ({1'b0, words_out} + 8'd1) >= {1'b0, half};
                expected_words.push_back(w);
                partial_word = 12'h000;
                words_out = words_out + 1'b1;
                if (w.last)
                    in_record = 1'b0;
            end
        end
    endtask

    task automatic check_word();
        word_beat_t w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word beat: addr %h idx %0d value %h last %b",
                     $time, record_address, word_index, word_value, last_word);
            mismatches++;
        end
        else
        begin
            w = expected_words.pop_front();
            if (record_address !== w.address)
            begin
                $display("%0t: record_address expected %h, got %h",
                         $time, w.address, record_address);
                mismatches++;
            end
            if (word_index !== w.index)
            begin
                $display("%0t: word_index expected %0d, got %0d",
                         $time, w.index, word_index);
                mismatches++;
            end
            if (word_value !== w.value)
            begin
                $display("%0t: word_value expected %h, got %h",
                         $time, w.value, word_value);
                mismatches++;
            end
            if (last_word !== w.last)
            begin
                $display("%0t: last_word expected %b, got %b",
                         $time, w.last, last_word);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr = 32'h0;
            char_pos = '0;
            in_record = 1'b0;
            byte_cnt = 8'h00;
            load_addr = 16'h0000;
            partial_word = 12'h000;
            words_out = '0;
            expected_words.delete();
            words_outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[2 +: ihex_pkg::REG_IDX_W] == ihex_pkg::REG_HIGH_BASE)
                base_addr = pwdata;
            // a word beat always stems from an earlier char beat: check first
            if (word_valid && !word_stall)
                check_word();
            if (char_valid && !char_stall)
                predict_char(ascii_char);
            words_outstanding <= expected_words.size();
        end
    end

endmodule

// ===== test/intel_hex_record_word_parser_tb.sv =====
`timescale 1ns / 100ps

// Drives character traffic into the parser and gives the verdict; all
// prediction and comparison lives in the checker.
module intel_hex_record_word_parser_tb;

    localparam logic [ihex_pkg::ADDR_W-1:0] HIGH_BASE_ADDR = {ihex_pkg::REG_HIGH_BASE, 2'b00};
    localparam logic [7:0]        CHAR_CR        = 8'h0D;
    localparam logic [7:0]        CHAR_LF        = 8'h0A;
    // cycles with no beat on either channel before we give up
    localparam int                HANG_LIMIT     = 4000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ihex_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           char_valid;
    logic                           char_stall;
    logic [7:0]                     ascii_char;
    logic                           word_valid;
    logic                           word_stall = 1'b0;
    logic [31:0]                    record_address;
    logic [ihex_pkg::WIDX_W-1:0]    word_index;
    logic [15:0]                    word_value;
    logic                           last_word;

    int                     fail_count;
    int                     words_outstanding;
    int                     char_idle_pct = 21;
    int                     word_stall_pct = 53;
    int                     chars_sent = 0;
    int                     hang_cycles = 0;

    always #4 clk = ~clk;

    intel_hex_record_word_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .ascii_char     (ascii_char),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .record_address (record_address),
        .word_index     (word_index),
        .word_value     (word_value),
        .last_word      (last_word)
    );

    ihex_word_checker word_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .char_valid         (char_valid),
        .char_stall         (char_stall),
        .ascii_char         (ascii_char),
        .word_valid         (word_valid),
        .word_stall         (word_stall),
        .record_address     (record_address),
        .word_index         (word_index),
        .word_value         (word_value),
        .last_word          (last_word),
        .fail_count         (fail_count),
        .words_outstanding  (words_outstanding)
    );

    // Receiver back-pressure: independent coin flip every cycle, so a word
    // beat can be held for any stretch, including right at the last word.
    always @(posedge clk)
    begin
        word_stall <= ($urandom_range(99) < word_stall_pct);
    end

    // Hang detector: only progress on a channel clears it.
    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (word_valid && !word_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return ihex_pkg::CHAR_0 + n;
        return ihex_pkg::CHAR_A + n - 8'd10;
    endfunction

    // Mostly clean upper-case digits; now and then any byte at all, which
    // covers lower case, non-hex junk and the odd stray ':' restart.
    function automatic logic [7:0] data_char();
        logic [7:0] c;
        if ($urandom_range(11) == 0)
            c = 8'($urandom_range(255));
        else
            c = hex_char(4'($urandom_range(15)));
        return c;
    endfunction

    // One char beat. Valid may drop for a random gap before the beat, but
    // never between two back-to-back beats in the same step.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < char_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        ascii_char <= c;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // A record with the given byte count and random address, type and data.
    // When allowed, about one record in ten is cut short; the next ':' then
    // lands mid-record and forces a restart.
    task automatic send_record(input logic [7:0] count, input bit may_cut);
        logic [7:0] rec[$];
        int         cut;
        int         i;
        rec.push_back(ihex_pkg::CHAR_COLON);
        rec.push_back(hex_char(count[7:4]));
        rec.push_back(hex_char(count[3:0]));
        for (i = 0; i < 6; i++)
            rec.push_back(hex_char(4'($urandom_range(15))));
        for (i = 0; i < 2 * count; i++)
            rec.push_back(data_char());
        cut = rec.size();
        if (may_cut && $urandom_range(9) == 0)
            cut = $urandom_range(1, rec.size() - 1);
        for (i = 0; i < cut; i++)
            send_char(rec[i]);
        if (cut == rec.size())
        begin
            // checksum and line end: ignored once the record closed
            send_char(hex_char(4'($urandom_range(15))));
            send_char(hex_char(4'($urandom_range(15))));
            send_char(CHAR_CR);
            send_char(CHAR_LF);
        end
    endtask

    // Random traffic until the running char count reaches target: well-formed
    // records dominate so data words are reached; short counts mostly, an
    // occasional longer one, some bursts of raw noise.
    task automatic run_traffic(input int target);
        int n;
        int i;
        while (chars_sent < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    send_char(8'($urandom_range(255)));
            end
            else if ($urandom_range(29) == 0)
                send_record(8'($urandom_range(17, 48)), 1'b1);
            else
                send_record(8'($urandom_range(0, 16)), 1'b1);
        end
    endtask

    // Drain: stop sending, wait for every predicted word, then idle before the
    // next phase.
    task automatic settle();
        char_valid <= 1'b0;
        @(posedge clk);
        while (words_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup then access; the register takes pwdata at the access edge.
    task automatic write_high_base(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HIGH_BASE_ADDR;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= 32'h0;
        char_valid <= 1'b0;
        ascii_char <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: base at its low extreme.
        write_high_base(32'h0000_0000);
        // extremes of the char byte, outside any record: dropped
        send_char(8'h00);
        send_char(8'hFF);
        // one full-scale word at the top address, flagged last
        send_text(":02FFFF00FFFF");
        // restart in the count field, then odd count with lower case in the
        // address: no word, record closes after the type, trailing F ignored
        send_text(":4");
        send_text(":01abCD00F");
        settle();

        // Sender idles lightly, receiver stalls heavily; base all ones.
        write_high_base(32'hFFFF_FFFF);
        run_traffic(120);
        settle();

        // Roles swapped; one maximum-count record runs word_index up to 126.
        char_idle_pct = 53;
        word_stall_pct = 21;
        write_high_base($urandom);
        send_record(8'hFF, 1'b0);
        run_traffic(670);
        settle();

        // Full rate on both sides.
        char_idle_pct = 0;
        word_stall_pct = 0;
        write_high_base($urandom);
        run_traffic(710);
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ihex_pkg.sv
hdl/intel_hex_record_word_parser.sv
test/ihex_word_checker.sv
test/intel_hex_record_word_parser_tb.sv
